// ----- rtl/ppbc_pkg.sv -----
// shared types and codes for the ping-pong buffer controller
package ppbc_pkg;

    typedef enum logic [1:0] {
        MODE_FREE       = 2'd0,
        MODE_FILLING    = 2'd1,
        MODE_READY      = 2'd2,
        MODE_PROCESSING = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_COMPLETE = 2'd0,
        OP_ACQUIRE  = 2'd1,
        OP_RELEASE  = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_OVERRUN = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    localparam int unsigned FIELD_BITS = 16;
    localparam logic [FIELD_BITS-1:0] OVR_MAX = 16'hFFFF;
    localparam logic [FIELD_BITS-1:0] CAPACITY_RESET = 16'hFFFF;
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

endpackage

// ----- rtl/ping_pong_buffer_controller.sv -----
// ping-pong double buffer controller: mode tracking, acquire, release, overrun count
//
// usage:
//   input channel (in_valid / in_stall) carries one command word: op, length_in,
//   buffer_sel. op complete closes the active buffer, acquire hands out the
//   lowest ready buffer, release frees a processing buffer.
//   output channel (out_valid / out_stall) returns exactly one result word per
//   command: status, buffer_out, length_out, overrun_total.
//   apb port holds buffer_capacity at byte address 0; pready is always high.
// timing:
//   a command is captured into an input register, then evaluated against the
//   buffer state combinationally and written to the result register, which
//   drives out_valid. one command per cycle is sustained while no result is
//   held by out_stall;
//   the state update in the evaluate stage is the only loop.
// reset:
//   buffer 0 filling and active, buffer 1 free, lengths and overrun count zero,
//   capacity 65535, both stages empty.
// stall:
//   while out_stall holds a pending result, the evaluate stage freezes; an empty
//   input register takes one more word, then in_stall rises.
module ping_pong_buffer_controller #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [ppbc_pkg::FIELD_BITS-1:0] length_in,
    input  logic                          buffer_sel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic                          buffer_out,
    output logic [ppbc_pkg::FIELD_BITS-1:0] length_out,
    output logic [ppbc_pkg::FIELD_BITS-1:0] overrun_total,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ppbc_pkg::*;

    logic                   cap_wr;
    logic [FIELD_BITS-1:0]  capacity_reg;

    logic                   in_valid_reg;
    op_t                    op_reg;
    logic [FIELD_BITS-1:0]  length_reg;
    logic                   sel_reg;

    mode_t                  mode_reg [2];
    mode_t                  mode_next [2];
    logic [LENGTH_BITS-1:0] len_reg [2];
    logic [LENGTH_BITS-1:0] len_next [2];
    logic                   active_reg;
    logic                   active_next;
    logic [FIELD_BITS-1:0]  overrun_reg;
    logic [FIELD_BITS-1:0]  overrun_next;

    logic                   out_valid_reg;
    status_t                status_reg;
    status_t                status_next;
    logic                   buf_out_reg;
    logic                   buf_out_next;
    logic [FIELD_BITS-1:0]  len_out_reg;
    logic [FIELD_BITS-1:0]  len_out_next;
    logic [FIELD_BITS-1:0]  ovr_out_reg;

    logic                   eval_go;
    logic                   eval_fire;
    logic                   in_take;
    logic                   cur;
    logic                   nxt;
    logic [31:0]            len_wide [2];

    // configuration port
    assign pready = 1'b1;
    assign cap_wr = psel && penable && pwrite && (paddr[2] == ADDR_CAPACITY[2]);
    assign prdata = (paddr[2] == ADDR_CAPACITY[2]) ? {16'd0, capacity_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cap_wr)
        begin
            capacity_reg <= pwdata[FIELD_BITS-1:0];
        end
    end

    // handshake
    assign eval_go   = !(out_valid_reg && out_stall);
    assign eval_fire = in_valid_reg && eval_go;
    assign in_stall  = in_valid_reg && !eval_go;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= OP_UNUSED;
            length_reg <= '0;
            sel_reg    <= 1'b0;
        end
        else if (in_take)
        begin
            op_reg     <= op_t'(op);
            length_reg <= length_in;
            sel_reg    <= buffer_sel;
        end
    end

    // evaluate
    assign cur = active_reg;
    assign nxt = ~active_reg;
    assign len_wide[0] = 32'(len_reg[0]);
    assign len_wide[1] = 32'(len_reg[1]);

    always_comb
    begin
        mode_next    = mode_reg;
        len_next     = len_reg;
        active_next  = active_reg;
        overrun_next = overrun_reg;
        status_next  = ST_BAD;
        buf_out_next = 1'b0;
        len_out_next = '0;
        unique case (op_reg)
            OP_COMPLETE:
            begin
                if (mode_reg[cur] == MODE_FILLING && length_reg <= capacity_reg)
                begin
                    len_next[cur]  = LENGTH_BITS'(length_reg);
                    mode_next[cur] = MODE_READY;
                    if (mode_reg[nxt] != MODE_FREE)
                    begin
                        if (overrun_reg != OVR_MAX)
                        begin
                            overrun_next = overrun_reg + 1'b1;
                        end
                        status_next = ST_OVERRUN;
                    end
                    else
                    begin
                        len_next[nxt]  = '0;
                        mode_next[nxt] = MODE_FILLING;
                        active_next    = nxt;
                        status_next    = ST_OK;
                    end
                end
            end
            OP_ACQUIRE:
            begin
                priority if (mode_reg[0] == MODE_READY)
                begin
                    mode_next[0] = MODE_PROCESSING;
                    buf_out_next = 1'b0;
                    len_out_next = len_wide[0][FIELD_BITS-1:0];
                    status_next  = ST_OK;
                end
                else if (mode_reg[1] == MODE_READY)
                begin
                    mode_next[1] = MODE_PROCESSING;
                    buf_out_next = 1'b1;
                    len_out_next = len_wide[1][FIELD_BITS-1:0];
                    status_next  = ST_OK;
                end
                else
                begin
                    status_next = ST_NONE;
                end
            end
            OP_RELEASE:
            begin
                if (mode_reg[sel_reg] == MODE_PROCESSING)
                begin
                    len_next[sel_reg]  = '0;
                    mode_next[sel_reg] = MODE_FREE;
                    status_next        = ST_OK;
                end
            end
            OP_UNUSED:
            begin
                status_next = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg[0] <= MODE_FILLING;
            mode_reg[1] <= MODE_FREE;
            len_reg[0]  <= '0;
            len_reg[1]  <= '0;
            active_reg  <= 1'b0;
            overrun_reg <= '0;
        end
        else if (eval_fire)
        begin
            mode_reg    <= mode_next;
            len_reg     <= len_next;
            active_reg  <= active_next;
            overrun_reg <= overrun_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eval_go)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_fire)
        begin
            status_reg  <= status_next;
            buf_out_reg <= buf_out_next;
            len_out_reg <= len_out_next;
            ovr_out_reg <= overrun_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign buffer_out    = buf_out_reg;
    assign length_out    = len_out_reg;
    assign overrun_total = ovr_out_reg;

`ifndef SYNTHESIS
    a_one_filling: assert property (@(posedge clk) disable iff (!rst_n)
        !(mode_reg[0] == MODE_FILLING && mode_reg[1] == MODE_FILLING))
        else $error("both buffers filling");

    a_overrun_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        eval_fire |=> overrun_reg >= $past(overrun_reg))
        else $error("overrun count decreased");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !eval_fire |=> (active_reg == $past(active_reg) && overrun_reg == $past(overrun_reg)))
        else $error("state changed without an evaluated word");
`endif

endmodule
